// ===== design/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: data widths, sector codes and the
// reciprocal constants for the divisions by constants.
// Depends on nothing; the converter top level imports it.
package hsv2rgb_pkg;

  localparam int HueFracBits = 4;
  localparam int HueW        = 16;
  localparam int ChanW       = 8;

  localparam int CodeMax     = 255;
  localparam int SectorDeg   = 60;
  localparam int SectorLen   = SectorDeg << HueFracBits;
  localparam int FracW       = $clog2(SectorLen);
  localparam int DistW       = $clog2(SectorLen + 1);

  localparam int DegW        = HueW - HueFracBits;
  localparam int QuotMax     = ((2 ** DegW) - 1) / SectorDeg;
  localparam int QuotW       = $clog2(QuotMax + 1);

  localparam int Div60Shift  = 22;
  localparam int Div60Mul    = ((2 ** Div60Shift) + SectorDeg - 1) / SectorDeg;
  localparam int Div6Shift   = 13;
  localparam int Div6Mul     = ((2 ** Div6Shift) + 5) / 6;
  localparam int Div255Shift = 24;
  localparam int Div255Mul   = ((2 ** Div255Shift) + CodeMax - 1) / CodeMax;

  localparam int LoProdW     = 2 * ChanW;
  localparam int NumW        = $clog2(CodeMax * SectorLen + 1);
  localparam int ProdW       = ChanW + NumW;
  localparam int ScaledMax   = CodeMax * CodeMax * SectorDeg;
  localparam int ScaledW     = $clog2(ScaledMax + 1);

  localparam longint MidDen   = longint'(CodeMax) * longint'(SectorDeg);
  localparam int     MidShift = 36;
  localparam longint MidMul   = ((64'sd1 <<< MidShift) + MidDen - 1) / MidDen;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_e;

endpackage

// ===== design/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter: throughput one transaction per clock while the output
// is not stalled; every accepted transaction reaches the output in order.
// Five register stages: hue split, sector and minimum, distance term,
// product, and the division by the sector scale with the channel select.
// A stall on a valid output freezes the whole pipeline; nothing is dropped.
// Asynchronous active-low reset clears the valid bits; data is not reset.
// Depends on hsv2rgb_pkg.
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] brightness_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  logic [4:0] valid_q;
  logic       advance;

  assign advance = !(valid_q[4] && stall_i);
  assign stall_o = !advance;
  assign valid_o = valid_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  // Stage 1: degree quotient and the product for the minimum channel.
  logic [HueW-1:0]    s1_hue_q;
  logic [QuotW-1:0]   s1_quot_q, s1_quot_d;
  logic [LoProdW-1:0] s1_lo_prod_q, s1_lo_prod_d;
  logic [ChanW-1:0]   s1_sat_q, s1_val_q;
  logic [DegW-1:0]    deg;
  logic [63:0]        quot_wide;

  always_comb begin
    deg          = hue_i[HueW-1:HueFracBits];
    quot_wide    = (64'(deg) * 64'(Div60Mul)) >> Div60Shift;
    s1_quot_d    = quot_wide[QuotW-1:0];
    s1_lo_prod_d = LoProdW'(brightness_i) * LoProdW'(8'(CodeMax) - saturation_i);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_hue_q     <= hue_i;
      s1_quot_q    <= s1_quot_d;
      s1_lo_prod_q <= s1_lo_prod_d;
      s1_sat_q     <= saturation_i;
      s1_val_q     <= brightness_i;
    end
  end

  // Stage 2: sector, position inside the sector and the minimum channel.
  sector_e          s2_sector_q, s2_sector_d;
  logic [FracW-1:0] s2_frac_q, s2_frac_d;
  logic [ChanW-1:0] s2_lo_q, s2_lo_d;
  logic [ChanW-1:0] s2_sat_q, s2_val_q;
  logic [63:0]      base_wide, six_quot, lo_wide;
  logic [HueW-1:0]  frac_full;

  always_comb begin
    base_wide   = (64'(s1_quot_q) * 64'(SectorDeg)) << HueFracBits;
    frac_full   = s1_hue_q - base_wide[HueW-1:0];
    s2_frac_d   = frac_full[FracW-1:0];
    six_quot    = ((64'(s1_quot_q) * 64'(Div6Mul)) >> Div6Shift) * 64'd6;
    s2_sector_d = sector_e'(3'(64'(s1_quot_q) - six_quot));
    lo_wide     = (64'(s1_lo_prod_q) * 64'(Div255Mul)) >> Div255Shift;
    s2_lo_d     = lo_wide[ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_sector_q <= s2_sector_d;
      s2_frac_q   <= s2_frac_d;
      s2_lo_q     <= s2_lo_d;
      s2_sat_q    <= s1_sat_q;
      s2_val_q    <= s1_val_q;
    end
  end

  // Stage 3: distance term and the numerator of the intermediate channel.
  sector_e          s3_sector_q;
  logic [NumW-1:0]  s3_num_q, s3_num_d;
  logic [ChanW-1:0] s3_lo_q, s3_val_q;
  logic [DistW-1:0] dist_len;

  always_comb begin
    if (s2_sector_q[0]) begin
      dist_len = DistW'(s2_frac_q);
    end else begin
      dist_len = DistW'(SectorLen) - DistW'(s2_frac_q);
    end
    s3_num_d = NumW'(CodeMax * SectorLen) - NumW'((ChanW + DistW)'(s2_sat_q) * dist_len);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_sector_q <= s2_sector_q;
      s3_num_q    <= s3_num_d;
      s3_lo_q     <= s2_lo_q;
      s3_val_q    <= s2_val_q;
    end
  end

  // Stage 4: value times numerator, fractional hue bits dropped.
  sector_e            s4_sector_q;
  logic [ScaledW-1:0] s4_scaled_q, s4_scaled_d;
  logic [ChanW-1:0]   s4_lo_q, s4_val_q;
  logic [ProdW-1:0]   num_prod;

  always_comb begin
    num_prod    = ProdW'(s3_val_q) * ProdW'(s3_num_q);
    s4_scaled_d = ScaledW'(num_prod >> HueFracBits);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_sector_q <= s3_sector_q;
      s4_scaled_q <= s4_scaled_d;
      s4_lo_q     <= s3_lo_q;
      s4_val_q    <= s3_val_q;
    end
  end

  // Stage 5: division by the sector scale and the channel select.
  logic [63:0]      mid_wide;
  logic [ChanW-1:0] mid;
  logic [ChanW-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;

  always_comb begin
    mid_wide = (64'(s4_scaled_q) * 64'(MidMul)) >> MidShift;
    mid      = mid_wide[ChanW-1:0];
    case (s4_sector_q)
      SEC_RED_YELLOW: begin
        red_d = s4_val_q; green_d = mid;      blue_d = s4_lo_q;
      end
      SEC_YELLOW_GREEN: begin
        red_d = mid;      green_d = s4_val_q; blue_d = s4_lo_q;
      end
      SEC_GREEN_CYAN: begin
        red_d = s4_lo_q;  green_d = s4_val_q; blue_d = mid;
      end
      SEC_CYAN_BLUE: begin
        red_d = s4_lo_q;  green_d = mid;      blue_d = s4_val_q;
      end
      SEC_BLUE_MAGENTA: begin
        red_d = mid;      green_d = s4_lo_q;  blue_d = s4_val_q;
      end
      default: begin
        red_d = s4_val_q; green_d = s4_lo_q;  blue_d = mid;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // The sector code left by the reduction must name one of the six sectors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (s2_sector_q != 3'd6) && (s2_sector_q != 3'd7))
    else $error("sector code out of range");

  // The position inside a sector stays below the sector length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (32'(s2_frac_q) < 32'(SectorLen)))
    else $error("position inside sector out of range");

  // The minimum channel never exceeds the brightness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (s2_lo_q <= s2_val_q))
    else $error("minimum channel above brightness");

  // The intermediate channel lies between the minimum and the brightness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> (mid <= s4_val_q) && (mid >= s4_lo_q))
    else $error("intermediate channel out of range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the HSV to RGB converter pipeline.
// The expected colour of every pixel is computed here in exact integer arithmetic and
// checked against each output transaction. Depends on hsv2rgb_pkg and hsv_to_rgb_converter_top.
module tb
  import hsv2rgb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SectorsPerTurn = 6;
  localparam int TurnLen        = SectorLen * SectorsPerTurn;
  localparam int MaxGap         = 9;
  localparam int DrainCycles    = 20;
  localparam int PrintLimit     = 30;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  logic             clk_i;
  logic             rst_ni;
  logic             valid_i;
  logic             stall_o;
  logic [HueW-1:0]  hue_i;
  logic [ChanW-1:0] saturation_i;
  logic [ChanW-1:0] brightness_i;
  logic             valid_o;
  logic             stall_i;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  rgb_t pending_rgb[$];
  int   failures;
  int   pixels_sent;
  int   pixels_checked;
  int   input_stall_cycles;
  int   hold_request;
  bit   sender_idle;
  bit   receiver_idle;

  hsv_to_rgb_converter_top u_top (
    .clk_i,
    .rst_ni,
    .valid_i,
    .stall_o,
    .hue_i,
    .saturation_i,
    .brightness_i,
    .valid_o,
    .stall_i,
    .red_o,
    .green_o,
    .blue_o
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic rgb_t rgb_from_hsv(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                                        logic [ChanW-1:0] bri);
    longint  angle;
    longint  frac;
    longint  dist_len;
    longint  v;
    longint  s;
    longint  top;
    longint  bottom;
    longint  middle;
    sector_e sector;
    rgb_t    colour;
    angle    = longint'(hue) % TurnLen;
    sector   = sector_e'(angle / SectorLen);
    frac     = angle % SectorLen;
    v        = longint'(bri);
    s        = longint'(sat);
    top      = v;
    bottom   = (v * (CodeMax - s)) / CodeMax;
    dist_len = sector[0] ? frac : SectorLen - frac;
    middle   = (v * CodeMax * SectorLen - v * s * dist_len) / (longint'(CodeMax) * SectorLen);
    case (sector)
      SEC_RED_YELLOW: begin
        colour = '{ChanW'(top), ChanW'(middle), ChanW'(bottom)};
      end
      SEC_YELLOW_GREEN: begin
        colour = '{ChanW'(middle), ChanW'(top), ChanW'(bottom)};
      end
      SEC_GREEN_CYAN: begin
        colour = '{ChanW'(bottom), ChanW'(top), ChanW'(middle)};
      end
      SEC_CYAN_BLUE: begin
        colour = '{ChanW'(bottom), ChanW'(middle), ChanW'(top)};
      end
      SEC_BLUE_MAGENTA: begin
        colour = '{ChanW'(middle), ChanW'(bottom), ChanW'(top)};
      end
      default: begin
        colour = '{ChanW'(top), ChanW'(bottom), ChanW'(middle)};
      end
    endcase
    return colour;
  endfunction

  task automatic report_failure(string msg);
    failures++;
    if (failures <= PrintLimit) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  task automatic check_colour(rgb_t got);
    rgb_t want;
    if (pending_rgb.size() == 0) begin
      report_failure($sformatf("output transaction with no pixel pending: r=%0d g=%0d b=%0d",
                               got.red, got.green, got.blue));
    end else begin
      want = pending_rgb.pop_front();
      pixels_checked++;
      if (got.red !== want.red) begin
        report_failure($sformatf("red: expected %0d, got %0d", want.red, got.red));
      end
      if (got.green !== want.green) begin
        report_failure($sformatf("green: expected %0d, got %0d", want.green, got.green));
      end
      if (got.blue !== want.blue) begin
        report_failure($sformatf("blue: expected %0d, got %0d", want.blue, got.blue));
      end
    end
  endtask

  task automatic send_pixel(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                            logic [ChanW-1:0] bri);
    int gap;
    bit taken;
    gap = sender_idle ? $urandom_range(MaxGap, 0) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= bri;
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      if (!taken) begin
        input_stall_cycles++;
      end
      @(posedge clk_i);
    end while (!taken);
    pending_rgb.push_back(rgb_from_hsv(hue, sat, bri));
    pixels_sent++;
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_rgb.size() != 0);
  endtask

  function automatic logic [ChanW-1:0] pick_code();
    logic [ChanW-1:0] code;
    case ($urandom_range(7, 0))
      0: begin
        code = '0;
      end
      1: begin
        code = '1;
      end
      default: begin
        code = ChanW'($urandom);
      end
    endcase
    return code;
  endfunction

  function automatic logic [HueW-1:0] pick_hue();
    logic [HueW-1:0] hue;
    case ($urandom_range(3, 0))
      0: begin
        hue = HueW'($urandom_range(SectorsPerTurn * 10, 0) * SectorLen
                    + $urandom_range(2, 0));
      end
      1: begin
        hue = HueW'($urandom_range(TurnLen - 1, 0));
      end
      default: begin
        hue = HueW'($urandom);
      end
    endcase
    return hue;
  endfunction

  task automatic test_corner_pixels();
    logic [HueW-1:0]  hues [20] = '{0, 960, 1920, 2880, 3840, 4800, 959, 5759, 5760, 65535,
                                    480, 3000, 1440, 2400, 16'hAAAA, 16'h5555, 4320, 1,
                                    5280, 11520};
    logic [ChanW-1:0] sats [20] = '{255, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                                    0, 255, 1, 128, 8'h55, 8'hAA, 255, 254, 200, 37};
    logic [ChanW-1:0] bris [20] = '{255, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                                    200, 0, 1, 255, 8'hAA, 8'h55, 128, 254, 100, 250};
    for (int i = 0; i < 20; i++) begin
      send_pixel(hues[i], sats[i], bris[i]);
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    for (int i = 0; i < 60; i++) begin
      send_pixel(pick_hue(), pick_code(), pick_code());
    end
    wait_drained();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  task automatic test_output_backpressure();
    sender_idle  = 1'b0;
    hold_request = 60;
    for (int i = 0; i < 24; i++) begin
      send_pixel(pick_hue(), pick_code(), pick_code());
    end
    wait_drained();
    sender_idle = 1'b1;
  endtask

  task automatic test_random_pixels();
    for (int i = 0; i < 350; i++) begin
      send_pixel(pick_hue(), pick_code(), pick_code());
      if ($urandom_range(99, 0) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int   hold;
      bit   seen;
      rgb_t got;
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
      end else begin
        hold = receiver_idle ? $urandom_range(MaxGap, 0) : 0;
      end
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        stall_i <= 1'b0;
      end
      do begin
        @(negedge clk_i);
        seen = valid_o;
        got  = '{red_o, green_o, blue_o};
        @(posedge clk_i);
      end while (!seen);
      check_colour(got);
    end
  end

  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    failures           = 0;
    pixels_sent        = 0;
    pixels_checked     = 0;
    input_stall_cycles = 0;
    hold_request       = 0;
    sender_idle        = 1'b1;
    receiver_idle      = 1'b1;
    rst_ni             = 1'b0;
    valid_i            = 1'b0;
    hue_i              = '0;
    saturation_i       = '0;
    brightness_i       = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_pixels();
    test_back_to_back();
    test_output_backpressure();
    test_random_pixels();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_rgb.size() != 0) begin
      report_failure($sformatf("%0d pixels never produced a result", pending_rgb.size()));
    end
    $display("Converted %0d pixels and checked %0d colours across all six sectors.",
             pixels_sent, pixels_checked);
    $display("Input was held off for %0d cycles under output back-pressure; %0d errors.",
             input_stall_cycles, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
